FILE: rtl/iad_pkg.sv
`default_nettype none

package iad_pkg;

    // fixed field widths
    localparam int CMD_W   = 3;
    localparam int INDEX_W = 4;
    localparam int DATA_W  = 32;
    localparam int CNT_W   = 5;
    localparam int STAT_W  = 2;

    // storage depth, bounded by the index and count field widths
    localparam int MAX_ENTRIES = 16;

    // capacity register value after reset
    localparam logic [CNT_W-1:0] CAP_RESET = 5'd16;

    typedef enum logic [CMD_W-1:0] {
        CMD_APPEND = 3'd0,
        CMD_INSERT = 3'd1,
        CMD_EDIT   = 3'd2,
        CMD_DELETE = 3'd3,
        CMD_DUMP   = 3'd4
    } cmd_t;

    typedef enum logic [STAT_W-1:0] {
        STATUS_DONE      = 2'd0,
        STATUS_FULL      = 2'd1,
        STATUS_BAD_INDEX = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_EXEC = 2'd1,
        ST_DUMP = 2'd2
    } state_t;

    typedef struct packed {
        logic [CMD_W-1:0]          command;
        logic [INDEX_W-1:0]        index;
        logic signed [DATA_W-1:0]  data_value;
    } in_word_t;

    typedef struct packed {
        logic [STAT_W-1:0]         status;
        logic signed [DATA_W-1:0]  element_value;
        logic                      element_valid;
        logic [CNT_W-1:0]          entry_count;
        logic                      is_full;
        logic                      is_empty;
        logic                      last_result;
    } out_word_t;

    // controller to datapath
    typedef struct packed {
        logic capture;
        logic exec;
        logic dump_step;
    } ctl_t;

    // datapath to controller
    typedef struct packed {
        logic slot_free;
        logic cmd_is_dump;
        logic list_empty;
        logic dump_last;
    } sts_t;

endpackage

`default_nettype wire

FILE: rtl/iad_ctrl.sv
`default_nettype none

module iad_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_ready,
    input  wire iad_pkg::sts_t sts,
    output iad_pkg::ctl_t      ctl
);

    iad_pkg::state_t state_reg;
    iad_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= iad_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        in_ready      = 1'b0;
        ctl.capture   = 1'b0;
        ctl.exec      = 1'b0;
        ctl.dump_step = 1'b0;
        case (state_reg)
            iad_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    ctl.capture = 1'b1;
                    state_next  = iad_pkg::ST_EXEC;
                end
            end
            iad_pkg::ST_EXEC:
            begin
                if (sts.slot_free)
                begin
                    if (sts.cmd_is_dump && !sts.list_empty)
                    begin
                        ctl.dump_step = 1'b1;
                        state_next    = sts.dump_last ? iad_pkg::ST_IDLE : iad_pkg::ST_DUMP;
                    end
                    else
                    begin
                        ctl.exec   = 1'b1;
                        state_next = iad_pkg::ST_IDLE;
                    end
                end
            end
            iad_pkg::ST_DUMP:
            begin
                if (sts.slot_free)
                begin
                    ctl.dump_step = 1'b1;
                    if (sts.dump_last)
                    begin
                        state_next = iad_pkg::ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = iad_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

FILE: rtl/iad_dpath.sv
`default_nettype none

module iad_dpath (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire iad_pkg::in_word_t                 in_data,
    input  wire logic                              out_ready,
    output logic                                   out_valid,
    output iad_pkg::out_word_t                     out_data,
    input  wire logic                              cfg_we,
    input  wire logic [iad_pkg::CNT_W-1:0]         cfg_wdata,
    input  wire iad_pkg::ctl_t                     ctl,
    output iad_pkg::sts_t                          sts
);

    localparam int          MAX_ENTRIES = iad_pkg::MAX_ENTRIES;
    localparam int          IDX_W   = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam logic [7:0]  MAX_ENT = 8'(MAX_ENTRIES);

    iad_pkg::in_word_t                  cmd_reg;
    logic [iad_pkg::CNT_W-1:0]          count_reg;
    logic [iad_pkg::CNT_W-1:0]          count_next;
    logic [iad_pkg::CNT_W-1:0]          cap_reg;
    logic [iad_pkg::CNT_W-1:0]          ptr_reg;
    logic signed [iad_pkg::DATA_W-1:0]  cell_reg  [MAX_ENTRIES];
    logic signed [iad_pkg::DATA_W-1:0]  cell_next [MAX_ENTRIES];
    logic                               out_valid_reg;
    iad_pkg::out_word_t                 out_reg;
    iad_pkg::out_word_t                 out_next;

    logic [7:0]   cap8;
    logic [7:0]   eff_cap;
    logic [7:0]   cnt8;
    logic [7:0]   idx8;
    logic [7:0]   cnt_next8;
    logic         full_now;
    logic [iad_pkg::STAT_W-1:0] status;
    logic         do_append;
    logic         do_insert;
    logic         do_edit;
    logic         do_delete;
    logic         load_out;

    // effective capacity: zero acts as one, clamp to storage depth
    always_comb
    begin
        cap8    = {3'b000, cap_reg};
        eff_cap = cap8;
        if (cap8 == 8'd0)
        begin
            eff_cap = 8'd1;
        end
        else if (cap8 > MAX_ENT)
        begin
            eff_cap = MAX_ENT;
        end
    end

    assign cnt8     = {3'b000, count_reg};
    assign idx8     = {4'b0000, cmd_reg.index};
    assign full_now = (cnt8 >= eff_cap);

    // decode of the held command
    always_comb
    begin
        status     = iad_pkg::STATUS_DONE;
        do_append  = 1'b0;
        do_insert  = 1'b0;
        do_edit    = 1'b0;
        do_delete  = 1'b0;
        count_next = count_reg;
        case (iad_pkg::cmd_t'(cmd_reg.command))
            iad_pkg::CMD_APPEND:
            begin
                if (full_now)
                begin
                    status = iad_pkg::STATUS_FULL;
                end
                else
                begin
                    do_append  = 1'b1;
                    count_next = 5'(count_reg + 5'd1);
                end
            end
            iad_pkg::CMD_INSERT:
            begin
                if (full_now)
                begin
                    status = iad_pkg::STATUS_FULL;
                end
                else if (idx8 > cnt8)
                begin
                    status = iad_pkg::STATUS_BAD_INDEX;
                end
                else
                begin
                    do_insert  = 1'b1;
                    count_next = 5'(count_reg + 5'd1);
                end
            end
            iad_pkg::CMD_EDIT:
            begin
                if (idx8 >= cnt8)
                begin
                    status = iad_pkg::STATUS_BAD_INDEX;
                end
                else
                begin
                    do_edit = 1'b1;
                end
            end
            iad_pkg::CMD_DELETE:
            begin
                if (idx8 >= cnt8)
                begin
                    status = iad_pkg::STATUS_BAD_INDEX;
                end
                else
                begin
                    do_delete  = 1'b1;
                    count_next = 5'(count_reg - 5'd1);
                end
            end
            default:
            begin
                status = iad_pkg::STATUS_DONE;
            end
        endcase
    end

    assign cnt_next8 = {3'b000, count_next};

    // one shift cell per entry, each sees only its neighbors
    for (genvar k = 0; k < MAX_ENTRIES; k++)
    begin : g_cell
        localparam logic [7:0] K = 8'(k);
        always_comb
        begin
            cell_next[k] = cell_reg[k];
            if (ctl.exec)
            begin
                if (do_append && K == cnt8)
                begin
                    cell_next[k] = cmd_reg.data_value;
                end
                if ((do_insert || do_edit) && K == idx8)
                begin
                    cell_next[k] = cmd_reg.data_value;
                end
                if (k > 0)
                begin
                    if (do_insert && K > idx8 && K <= cnt8)
                    begin
                        cell_next[k] = cell_reg[(k > 0) ? k - 1 : 0];
                    end
                end
                if (k < MAX_ENTRIES - 1)
                begin
                    if (do_delete && K >= idx8 && 8'(K + 8'd1) < cnt8)
                    begin
                        cell_next[k] = cell_reg[(k < MAX_ENTRIES - 1) ? k + 1 : k];
                    end
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < MAX_ENTRIES; k++)
        begin
            cell_reg[k] <= cell_next[k];
        end
    end

    // command hold, count, capacity and dump pointer
    always_ff @(posedge clk)
    begin
        if (ctl.capture)
        begin
            cmd_reg <= in_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            cap_reg   <= iad_pkg::CAP_RESET;
            ptr_reg   <= '0;
        end
        else
        begin
            if (ctl.exec)
            begin
                count_reg <= count_next;
            end
            if (cfg_we)
            begin
                cap_reg <= cfg_wdata;
            end
            if (ctl.capture)
            begin
                ptr_reg <= '0;
            end
            else if (ctl.dump_step)
            begin
                ptr_reg <= 5'(ptr_reg + 5'd1);
            end
        end
    end

    // output word
    always_comb
    begin
        out_next.status        = status;
        out_next.element_value = '0;
        out_next.element_valid = 1'b0;
        out_next.entry_count   = count_next;
        out_next.is_full       = (cnt_next8 >= eff_cap);
        out_next.is_empty      = (count_next == '0);
        out_next.last_result   = 1'b1;
        if (ctl.dump_step)
        begin
            out_next.status        = iad_pkg::STATUS_DONE;
            out_next.element_value = cell_reg[IDX_W'(ptr_reg)];
            out_next.element_valid = 1'b1;
            out_next.entry_count   = count_reg;
            out_next.is_full       = full_now;
            out_next.is_empty      = 1'b0;
            out_next.last_result   = sts.dump_last;
        end
    end

    assign load_out = ctl.exec || ctl.dump_step;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_reg <= out_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    assign sts.slot_free   = !out_valid_reg || out_ready;
    assign sts.cmd_is_dump = (iad_pkg::cmd_t'(cmd_reg.command) == iad_pkg::CMD_DUMP);
    assign sts.list_empty  = (count_reg == '0);
    assign sts.dump_last   = (5'(ptr_reg + 5'd1) == count_reg);

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt8 <= MAX_ENT)
        else $error("entry count beyond storage depth");

    a_one_load: assert property (@(posedge clk) disable iff (!rst_n)
        !(ctl.exec && ctl.dump_step))
        else $error("execute and dump step in the same cycle");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        load_out |-> (!out_valid_reg || out_ready))
        else $error("output word overwritten before it was taken");

    a_count_on_exec: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != $past(count_reg)) |-> $past(ctl.exec))
        else $error("entry count changed without a command");

    a_dump_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.dump_step |-> (ptr_reg < count_reg))
        else $error("dump read past the stored entries");
`endif

endmodule

`default_nettype wire

FILE: rtl/indexed_array_insert_delete_core.sv
// bounded packed list of signed 32-bit values with insert and delete shifting
//
// in channel (in_valid/in_ready, in_data): one command word - append, insert
// at index, edit, delete or dump. out channel (out_valid/out_ready, out_data):
// result words, one per command, or one per stored entry for a dump of a
// non-empty list; last_result marks the final word of a command.
// cfg_we/cfg_wdata write the capacity register at once; write only while idle.
//
// sequence: a command is taken while idle and executed in the execute state
// that follows, as soon as the output register is free; its result word is
// loaded into the output register. a dump reads one stored entry per cycle,
// while the output register is free, from the shift cells through the dump
// pointer. insert and delete move all entries together in the execute step.
//
// a command word is taken while the previous result word still waits in the
// output register; execution waits until that word is taken. back pressure on
// out_ready holds the controller, no word is dropped.
//
// reset clears the count, sets capacity to 16 and empties the output register;
// the entry cells are not cleared and are never read beyond the count.
`default_nettype none

module indexed_array_insert_delete_core (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    // command channel
    input  wire logic                       in_valid,
    output logic                            in_ready,
    input  wire iad_pkg::in_word_t          in_data,
    // result channel
    output logic                            out_valid,
    input  wire logic                       out_ready,
    output iad_pkg::out_word_t              out_data,
    // capacity register
    input  wire logic                       cfg_we,
    input  wire logic [iad_pkg::CNT_W-1:0]  cfg_wdata
);

    // command and status between the controller and the datapath
    iad_pkg::ctl_t ctl;
    iad_pkg::sts_t sts;

    // sequencing: idle, execute, dump walk
    iad_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .ctl      (ctl)
    );

    // shift cells, count, capacity and output register
    iad_dpath u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .out_ready (out_ready),
        .out_valid (out_valid),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .ctl       (ctl),
        .sts       (sts)
    );

endmodule

`default_nettype wire
